// ===== rtl/spl_pkg.sv =====
// Shared types, codes and helpers for the sorted priority list.
// No dependencies.
package spl_pkg;

	localparam int DEPTH_DEF        = 64;
	localparam int HANDLE_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ACT_INSERT     = 3'd0,
		ACT_REM_INDEX  = 3'd1,
		ACT_REM_SLICE  = 3'd2,
		ACT_REM_HANDLE = 3'd3,
		ACT_REM_PRANGE = 3'd4,
		ACT_READ       = 3'd5
	} action_t;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	localparam logic [1:0] ORD_GT = 2'd0;
	localparam logic [1:0] ORD_GE = 2'd1;
	localparam logic [1:0] ORD_LT = 2'd2;
	localparam logic [1:0] ORD_LE = 2'd3;

	localparam logic [1:0] ORDER_MODE_RESET = ORD_LE;

	typedef struct packed {
		logic [1:0]         status;
		logic [6:0]         entry_count;
		logic signed [31:0] read_priority;
		logic [31:0]        read_handle;
	} result_t;

	// stored priority checked against the new one
	function automatic logic order_pass(logic signed [31:0] stored,
			logic signed [31:0] p, logic [1:0] mode);
		logic r;
		case (mode)
			ORD_GT:  r = stored > p;
			ORD_GE:  r = stored >= p;
			ORD_LT:  r = stored < p;
			default: r = stored <= p;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/spl_mem.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on nothing.
module spl_mem #(
	parameter int DEPTH = 64,
	parameter int EW    = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [EW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [EW-1:0]            rdata
);

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/spl_ctrl.sv =====
// Sequencer: scans and shifts the entry store one entry per cycle.
// Depends on spl_pkg; drives spl_mem ports.
module spl_ctrl #(
	parameter int DEPTH        = spl_pkg::DEPTH_DEF,
	parameter int HANDLE_WIDTH = spl_pkg::HANDLE_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH),
	localparam int EW = 32 + HANDLE_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] priority_req,
	input  logic signed [31:0] priority_b,
	input  logic [31:0]        item_handle,
	input  logic [6:0]         index_a,
	input  logic [6:0]         index_b,
	input  logic [1:0]         order_mode,
	output logic               res_valid,
	input  logic               res_ready,
	output spl_pkg::result_t   res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output logic [EW-1:0]      mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  logic [EW-1:0]      mem_rdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 7) ? CW : 7;
	localparam int HW = HANDLE_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SHDN, S_SHUP, S_RD, S_RDW, S_FIN
	} state_t;

	state_t                state_q;
	spl_pkg::action_t      kind_q;
	logic signed [31:0]    pa_q, lo_q, hi_q;
	logic [HW-1:0]         hdl_q;
	logic [CW-1:0]         count_q, ptr_q, ridx_s1, n_q, pos_q, first_q, last_q;
	logic                  rv_s1, found_q;
	logic [AW-1:0]         ia_q;
	logic [1:0]            st_q;
	logic signed [31:0]    rp_q;
	logic [31:0]           rh_q;

	logic signed [31:0]    rd_p;
	logic [HW-1:0]         rd_h;
	logic                  stop, issue, scan_end, sh_end, in_match;
	logic [XW-1:0]         ia_x, ib_x, cnt_x, slo_x, shi_x;
	logic [HW-1:0]         hdl_in;

	assign rd_p   = mem_rdata[EW-1:HW];
	assign rd_h   = mem_rdata[HW-1:0];
	assign hdl_in = HW'(item_handle);
	assign ia_x   = XW'(index_a);
	assign ib_x   = XW'(index_b);
	assign cnt_x  = XW'(count_q);
	assign slo_x  = (ia_x <= ib_x) ? ia_x : ib_x;
	assign shi_x  = (ia_x <= ib_x) ? ib_x : ia_x;

	always_comb begin
		stop = 1'b0;
		case (kind_q)
			spl_pkg::ACT_INSERT:     stop = spl_pkg::order_pass(rd_p, pa_q, order_mode);
			spl_pkg::ACT_REM_HANDLE: stop = (rd_h == hdl_q);
			spl_pkg::ACT_REM_PRANGE: stop = (rd_p > hi_q);
			default:                 stop = 1'b0;
		endcase
		stop = stop && rv_s1 && (state_q == S_SCAN);
		in_match = rv_s1 && !(rd_p < lo_q) && !(rd_p > hi_q);
	end

	always_comb begin
		issue = 1'b0;
		mem_raddr = ptr_q[AW-1:0];
		case (state_q)
			S_SCAN, S_SHDN: issue = !stop && (ptr_q < count_q);
			S_SHUP: begin
				issue = ptr_q > pos_q;
				mem_raddr = AW'(ptr_q - 1'b1);
			end
			S_RD: begin
				issue = 1'b1;
				mem_raddr = ia_q;
			end
			default: issue = 1'b0;
		endcase
		mem_re   = issue;
		scan_end = stop || (!rv_s1 && !issue);
		sh_end   = !rv_s1 && !issue;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(ridx_s1 - n_q);
		mem_wdata = mem_rdata;
		case (state_q)
			S_SHDN: mem_we = rv_s1;
			S_SHUP: begin
				if (rv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(ridx_s1 + 1'b1);
				end else if (sh_end) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = {pa_q, hdl_q};
				end
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res.status        = st_q;
	assign res.entry_count   = 7'(count_q);
	assign res.read_priority = rp_q;
	assign res.read_handle   = rh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rv_s1   <= 1'b0;
		end else begin
			rv_s1   <= issue && (state_q != S_RD);
			ridx_s1 <= (state_q == S_SHUP) ? CW'(ptr_q - 1'b1) : ptr_q;
			if (issue) begin
				ptr_q <= (state_q == S_SHUP) ? CW'(ptr_q - 1'b1) : CW'(ptr_q + 1'b1);
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= spl_pkg::action_t'(action);
						pa_q    <= priority_req;
						lo_q    <= (priority_req < priority_b) ? priority_req : priority_b;
						hi_q    <= (priority_req < priority_b) ? priority_b : priority_req;
						hdl_q   <= hdl_in;
						rp_q    <= '0;
						rh_q    <= '0;
						st_q    <= spl_pkg::ST_DONE;
						ptr_q   <= '0;
						found_q <= 1'b0;
						case (action)
							spl_pkg::ACT_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									st_q    <= spl_pkg::ST_FULL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_SCAN;
								end
							end
							spl_pkg::ACT_REM_INDEX: begin
								if (ia_x >= cnt_x) begin
									st_q    <= spl_pkg::ST_RANGE;
									state_q <= S_FIN;
								end else begin
									ptr_q   <= CW'(ia_x + 1'b1);
									n_q     <= CW'(1);
									state_q <= S_SHDN;
								end
							end
							spl_pkg::ACT_REM_SLICE: begin
								if (ia_x > cnt_x || ib_x > cnt_x) begin
									st_q    <= spl_pkg::ST_RANGE;
									state_q <= S_FIN;
								end else if (slo_x == shi_x) begin
									state_q <= S_FIN;
								end else begin
									ptr_q   <= CW'(shi_x);
									n_q     <= CW'(shi_x - slo_x);
									state_q <= S_SHDN;
								end
							end
							spl_pkg::ACT_REM_HANDLE, spl_pkg::ACT_REM_PRANGE: begin
								state_q <= S_SCAN;
							end
							spl_pkg::ACT_READ: begin
								if (ia_x >= cnt_x) begin
									st_q    <= spl_pkg::ST_RANGE;
									state_q <= S_FIN;
								end else begin
									ia_q    <= AW'(ia_x);
									state_q <= S_RD;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_SCAN: begin
					if (kind_q == spl_pkg::ACT_REM_PRANGE && in_match && !stop) begin
						found_q <= 1'b1;
						last_q  <= ridx_s1;
						if (!found_q) begin
							first_q <= ridx_s1;
						end
					end
					if (scan_end) begin
						rv_s1 <= 1'b0;
						case (kind_q)
							spl_pkg::ACT_INSERT: begin
								pos_q   <= stop ? ridx_s1 : count_q;
								ptr_q   <= count_q;
								state_q <= S_SHUP;
							end
							spl_pkg::ACT_REM_HANDLE: begin
								if (stop) begin
									ptr_q   <= CW'(ridx_s1 + 1'b1);
									n_q     <= CW'(1);
									state_q <= S_SHDN;
								end else begin
									st_q    <= spl_pkg::ST_NOMATCH;
									state_q <= S_FIN;
								end
							end
							default: begin
								if (found_q) begin
									ptr_q   <= CW'(last_q + 1'b1);
									n_q     <= CW'(last_q - first_q + 1'b1);
									state_q <= S_SHDN;
								end else begin
									st_q    <= spl_pkg::ST_NOMATCH;
									state_q <= S_FIN;
								end
							end
						endcase
					end
				end
				S_SHDN: begin
					if (sh_end) begin
						count_q <= count_q - n_q;
						state_q <= S_FIN;
					end
				end
				S_SHUP: begin
					if (sh_end) begin
						count_q <= CW'(count_q + 1'b1);
						state_q <= S_FIN;
					end
				end
				S_RD:  state_q <= S_RDW;
				S_RDW: begin
					rp_q    <= rd_p;
					rh_q    <= 32'(rd_h);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/sorted_priority_list.sv =====
// Each request runs as a sequence: a read fetches one entry; index/slice removal shifts down the entries
// after the removed span; handle/range removal scans the list and then shifts; insert scans to the
// insertion point and then shifts the tail up to make room.
// One request at a time; the single read port of the entry store paces scan and shift.
// Reset (arst_n low): entry count 0, order_mode 3, no result pending; entries are not cleared.
// Depends on spl_pkg, spl_mem, spl_ctrl.
module sorted_priority_list #(
	parameter int DEPTH        = spl_pkg::DEPTH_DEF,
	parameter int HANDLE_WIDTH = spl_pkg::HANDLE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration: order_mode
	input  logic               cfg_we,
	input  logic [1:0]         cfg_wdata,
	// request items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         action,
	input  logic signed [31:0] priority_req,
	input  logic signed [31:0] priority_b,
	input  logic [31:0]        item_handle,
	input  logic [6:0]         index_a,
	input  logic [6:0]         index_b,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [6:0]         entry_count,
	output logic signed [31:0] read_priority,
	output logic [31:0]        read_handle
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = 32 + HANDLE_WIDTH;

	logic [1:0]       order_mode_q;
	logic             out_valid_q;
	spl_pkg::result_t out_q;

	logic             res_valid, res_ready;
	spl_pkg::result_t res;

	logic             mem_we, mem_re;
	logic [AW-1:0]    mem_waddr, mem_raddr;
	logic [EW-1:0]    mem_wdata, mem_rdata;

	// Insert comparison mode; the user must write it only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= spl_pkg::ORDER_MODE_RESET;
		end else if (cfg_we) begin
			order_mode_q <= cfg_wdata;
		end
	end

	// Entries are {priority, handle}, in list order from address 0.
	spl_mem #(
		.DEPTH (DEPTH),
		.EW    (EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	spl_ctrl #(
		.DEPTH        (DEPTH),
		.HANDLE_WIDTH (HANDLE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.priority_req (priority_req),
		.priority_b   (priority_b),
		.item_handle  (item_handle),
		.index_a      (index_a),
		.index_b      (index_b),
		.order_mode   (order_mode_q),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	// Output register: the sequencer may take the next item while a result waits here.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign entry_count   = out_q.entry_count;
	assign read_priority = out_q.read_priority;
	assign read_handle   = out_q.read_handle;

endmodule

// ===== rtl/spl_checker.sv =====
// Port-level checks on the sorted priority list, bound to the top level.
// Depends on spl_pkg and sorted_priority_list.
module spl_assert #(
	parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [6:0]         entry_count,
	input logic signed [31:0] read_priority,
	input logic [31:0]        read_handle
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
		else $error("result changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spl_pkg::ST_FULL |-> entry_count == 7'(DEPTH))
		else $error("full status with table not full");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != spl_pkg::ST_DONE |-> read_priority == 0 && read_handle == 0)
		else $error("read fields set on failed action");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(entry_count) <= DEPTH)
		else $error("entry count beyond depth");

endmodule

bind sorted_priority_list spl_assert #(.DEPTH(DEPTH)) u_spl_assert (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.entry_count   (entry_count),
	.read_priority (read_priority),
	.read_handle   (read_handle)
);
